// ===== rtl/core/s2eig_pkg.sv =====
// Package for the symmetric 2x2 eigenvalue and Jacobian unit.
// Holds the format constants and derived widths; depends on nothing.
package s2eig_pkg;
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIFF_W     = DATA_WIDTH + 1;
  localparam int SQ_W       = DATA_WIDTH + 1;
  localparam int D_W        = 2 * SQ_W;
  localparam int REM_W      = SQ_W + 4;
  localparam int DREM_W     = SQ_W + 1;
  localparam int DIV_N      = FRAC_BITS + 1;
  localparam int LAMBDA_W   = DATA_WIDTH + 2;
  localparam int JAC_W      = FRAC_BITS + 2;
  localparam int LATENCY    = 3 + SQ_W + DIV_N + 1;
endpackage

// ===== rtl/core/sym2x2_eigen_with_jacobian_unit.sv =====
// Top level: eigenvalues and eigenvalue Jacobian of a symmetric 2x2 matrix.
// Uses s2eig_pkg for widths; contains the full pipeline.
// Stages in order: 1, 2, discriminant, square-root (one root bit each),
// divider (one quotient bit each) and the registered output stage.
// Throughput: one beat per cycle; busy is always low, results cannot stall.
// Reset (rst, synchronous): clears all stage valid bits and done.
module sym2x2_eigen_with_jacobian_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [s2eig_pkg::DATA_WIDTH-1:0] diag_a,
  input  logic signed [s2eig_pkg::DATA_WIDTH-1:0] diag_b,
  input  logic signed [s2eig_pkg::DATA_WIDTH-1:0] offdiag_kelvin,
  output logic                                  done,
  output logic signed [s2eig_pkg::LAMBDA_W-1:0] lambda_low,
  output logic signed [s2eig_pkg::LAMBDA_W-1:0] lambda_high,
  output logic signed [s2eig_pkg::JAC_W-1:0]    dlow_da,
  output logic signed [s2eig_pkg::JAC_W-1:0]    dlow_db,
  output logic signed [s2eig_pkg::JAC_W-1:0]    dlow_dc,
  output logic signed [s2eig_pkg::JAC_W-1:0]    dhigh_da,
  output logic signed [s2eig_pkg::JAC_W-1:0]    dhigh_db,
  output logic signed [s2eig_pkg::JAC_W-1:0]    dhigh_dc,
  output logic                                  degenerate
);
  localparam int DW  = s2eig_pkg::DATA_WIDTH;
  localparam int SQN = s2eig_pkg::SQ_W;
  localparam int DVN = s2eig_pkg::DIV_N;

  assign busy = 1'b0;

  // stage 1: difference, sum, magnitudes
  logic                             v1;
  logic [s2eig_pkg::DIFF_W-1:0]     ud1;
  logic [DW-1:0]                    uc1;
  logic signed [s2eig_pkg::DIFF_W-1:0] sum1;
  logic                             nd1, nc1;
  logic signed [s2eig_pkg::DIFF_W-1:0] diff0;

  assign diff0 = {diag_a[DW-1], diag_a} - {diag_b[DW-1], diag_b};

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
    ud1  <= diff0[DW] ? -diff0 : diff0;
    uc1  <= offdiag_kelvin[DW-1] ? -offdiag_kelvin : offdiag_kelvin;
    sum1 <= {diag_a[DW-1], diag_a} + {diag_b[DW-1], diag_b};
    nd1  <= diff0[DW];
    nc1  <= offdiag_kelvin[DW-1];
  end

  // stage 2: squares
  logic                             v2;
  logic [2*s2eig_pkg::DIFF_W-1:0]   dd2;
  logic [2*DW-1:0]                  cc2;
  logic [s2eig_pkg::DIFF_W-1:0]     ud2;
  logic [DW-1:0]                    uc2;
  logic signed [s2eig_pkg::DIFF_W-1:0] sum2;
  logic                             nd2, nc2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    dd2  <= ud1 * ud1;
    cc2  <= uc1 * uc1;
    ud2  <= ud1;
    uc2  <= uc1;
    sum2 <= sum1;
    nd2  <= nd1;
    nc2  <= nc1;
  end

  // square-root stage arrays; index 0 is the discriminant stage
  logic                          sv    [SQN+1];
  logic [s2eig_pkg::D_W-1:0]     sd    [SQN+1];
  logic [s2eig_pkg::REM_W-1:0]   srem  [SQN+1];
  logic [SQN-1:0]                sroot [SQN+1];
  logic [s2eig_pkg::DIFF_W-1:0]  sud   [SQN+1];
  logic [DW-1:0]                 suc   [SQN+1];
  logic signed [s2eig_pkg::DIFF_W-1:0] ssum [SQN+1];
  logic                          snd   [SQN+1];
  logic                          snc   [SQN+1];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else     sv[0] <= v2;
    sd[0]    <= dd2 + {{(s2eig_pkg::D_W-2*DW-1){1'b0}}, cc2, 1'b0};
    srem[0]  <= '0;
    sroot[0] <= '0;
    sud[0]   <= ud2;
    suc[0]   <= uc2;
    ssum[0]  <= sum2;
    snd[0]   <= nd2;
    snc[0]   <= nc2;
  end

  for (genvar i = 0; i < SQN; i++) begin : g_sqrt
    logic [s2eig_pkg::REM_W-1:0] rem_sh;
    logic [s2eig_pkg::REM_W-1:0] trial;
    logic                        ge;
    assign rem_sh = {srem[i][s2eig_pkg::REM_W-3:0],
                     sd[i][s2eig_pkg::D_W-1:s2eig_pkg::D_W-2]};
    assign trial  = {{(s2eig_pkg::REM_W-SQN-2){1'b0}}, sroot[i], 2'b01};
    assign ge     = rem_sh >= trial;
    always_ff @(posedge clk) begin
      if (rst) sv[i+1] <= 1'b0;
      else     sv[i+1] <= sv[i];
      sd[i+1]    <= {sd[i][s2eig_pkg::D_W-3:0], 2'b00};
      srem[i+1]  <= ge ? rem_sh - trial : rem_sh;
      sroot[i+1] <= {sroot[i][SQN-2:0], ge};
      sud[i+1]   <= sud[i];
      suc[i+1]   <= suc[i];
      ssum[i+1]  <= ssum[i];
      snd[i+1]   <= snd[i];
      snc[i+1]   <= snc[i];
    end
  end

  // divider stage arrays, both quotients in parallel
  logic                          qv   [DVN+1];
  logic [s2eig_pkg::DREM_W-1:0]  qra  [DVN+1];
  logic [s2eig_pkg::DREM_W-1:0]  qrc  [DVN+1];
  logic [DVN-1:0]                qqa  [DVN+1];
  logic [DVN-1:0]                qqc  [DVN+1];
  logic [SQN-1:0]                qs   [DVN+1];
  logic signed [s2eig_pkg::DIFF_W-1:0] qsum [DVN+1];
  logic                          qnd  [DVN+1];
  logic                          qnc  [DVN+1];

  assign qv[0]   = sv[SQN];
  assign qra[0]  = {1'b0, sud[SQN]};
  assign qrc[0]  = {2'b00, suc[SQN]};
  assign qqa[0]  = '0;
  assign qqc[0]  = '0;
  assign qs[0]   = sroot[SQN];
  assign qsum[0] = ssum[SQN];
  assign qnd[0]  = snd[SQN];
  assign qnc[0]  = snc[SQN];

  for (genvar j = 0; j < DVN; j++) begin : g_div
    logic [s2eig_pkg::DREM_W-1:0] ta, tc, den;
    logic                         ga, gc;
    assign den = {1'b0, qs[j]};
    assign ta  = (j == 0) ? qra[j] : {qra[j][s2eig_pkg::DREM_W-2:0], 1'b0};
    assign tc  = (j == 0) ? qrc[j] : {qrc[j][s2eig_pkg::DREM_W-2:0], 1'b0};
    assign ga  = ta >= den;
    assign gc  = tc >= den;
    always_ff @(posedge clk) begin
      if (rst) qv[j+1] <= 1'b0;
      else     qv[j+1] <= qv[j];
      qra[j+1]  <= ga ? ta - den : ta;
      qrc[j+1]  <= gc ? tc - den : tc;
      qqa[j+1]  <= {qqa[j][DVN-2:0], ga};
      qqc[j+1]  <= {qqc[j][DVN-2:0], gc};
      qs[j+1]   <= qs[j];
      qsum[j+1] <= qsum[j];
      qnd[j+1]  <= qnd[j];
      qnc[j+1]  <= qnc[j];
    end
  end

  // output stage
  logic signed [s2eig_pkg::JAC_W:0]    qsg, one_x, mh, ph;
  logic signed [s2eig_pkg::JAC_W-1:0]  rsg;
  logic signed [s2eig_pkg::LAMBDA_W:0] sum_x, s_x, lo_x, hi_x;
  logic                                degen;

  assign degen = qs[DVN] == '0;
  assign one_x = (s2eig_pkg::JAC_W+1)'(1) <<< s2eig_pkg::FRAC_BITS;
  assign qsg   = qnd[DVN] ? -$signed({2'b00, qqa[DVN]}) : $signed({2'b00, qqa[DVN]});
  assign rsg   = qnc[DVN] ? -$signed({1'b0, qqc[DVN]}) : $signed({1'b0, qqc[DVN]});
  assign mh    = (one_x - qsg) >>> 1;
  assign ph    = (one_x + qsg) >>> 1;
  assign sum_x = {{2{qsum[DVN][DW]}}, qsum[DVN]};
  assign s_x   = {2'b00, qs[DVN]};
  assign lo_x  = (sum_x - s_x) >>> 1;
  assign hi_x  = (sum_x + s_x) >>> 1;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= qv[DVN];
    lambda_low  <= lo_x[s2eig_pkg::LAMBDA_W-1:0];
    lambda_high <= hi_x[s2eig_pkg::LAMBDA_W-1:0];
    dlow_da     <= degen ? '0 : mh[s2eig_pkg::JAC_W-1:0];
    dlow_db     <= degen ? '0 : ph[s2eig_pkg::JAC_W-1:0];
    dlow_dc     <= degen ? '0 : -rsg;
    dhigh_da    <= degen ? '0 : ph[s2eig_pkg::JAC_W-1:0];
    dhigh_db    <= degen ? '0 : mh[s2eig_pkg::JAC_W-1:0];
    dhigh_dc    <= degen ? '0 : rsg;
    degenerate  <= degen;
  end

  a_busy_low: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_done_traces_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, s2eig_pkg::LATENCY))
    else $error("result without a start");
  a_degen_equal: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (lambda_low == lambda_high && dlow_dc == '0))
    else $error("degenerate result not collapsed");
  a_jac_sum: assert property (@(posedge clk) disable iff (rst)
    (done && !degenerate) |-> (dlow_dc == -dhigh_dc && dlow_da == dhigh_db))
    else $error("Jacobian symmetry broken");
endmodule
